FILE: src/tng_pkg.sv
// Shared types and constants for the three-tone noise sound generator.
// No dependencies; tng_core, tng_out and the top level import this package.
package tng_pkg;

    // Request kinds
    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_WRITE = 1'b1
    } t_kind;

    // Sound register indexes
    localparam logic [2:0] REG_MASTER_FREQ = 3'd0;
    localparam logic [2:0] REG_TONE_A_FREQ = 3'd1;
    localparam logic [2:0] REG_TONE_B_FREQ = 3'd2;
    localparam logic [2:0] REG_TONE_C_FREQ = 3'd3;
    localparam logic [2:0] REG_VIBRATO     = 3'd4;
    localparam logic [2:0] REG_NOISE_CTRL  = 3'd5;
    localparam logic [2:0] REG_VOLUME_AB   = 3'd6;
    localparam logic [2:0] REG_NOISE_VOL   = 3'd7;

    localparam int NUM_REGS   = 8;
    localparam int NUM_TONES  = 3;
    localparam int SAMPLE_W   = 6;
    localparam int PRESCALE_W = 6;
    localparam int VIB_W      = 13;
    localparam int NOISE_W    = 15;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 6'd60;

    // Bit positions within the control registers
    localparam int BLOCK_XFER_POS = 3;   // port bit for block-transfer decode
    localparam int NOISE_EN_POS   = 5;   // register 5
    localparam int MUX_NOISE_POS  = 4;   // register 5
    localparam logic [3:0] VIB_TEST_POS = 4'd9;
    localparam logic [5:0] PRESCALE_LAST = 6'd63;

    // Mixer output toward the result register
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
    } t_result;

endpackage

FILE: src/tng_in_if.sv
// Request channel of the sound generator: valid/ready plus the request fields.
// Depends on nothing.
interface tng_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] port;
    logic [7:0] addr_high;
    logic [7:0] write_data;

    modport source (output valid, kind, port, addr_high, write_data, input ready);
    modport sink   (input valid, kind, port, addr_high, write_data, output ready);
endinterface

FILE: src/tng_out_if.sv
// Result channel of the sound generator: valid/ready plus the mixed sample.
// Depends on nothing.
interface tng_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

FILE: src/tng_core.sv
// Sound register file, oscillators, LFSR and mixer; all updated in one pass per request.
// Depends on tng_pkg.
module tng_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_kind,
    input  logic [7:0]        i_port,
    input  logic [7:0]        i_addr_high,
    input  logic [7:0]        i_write_data,
    output tng_pkg::t_result  o_result
);
    import tng_pkg::*;

    logic [7:0]            r_regs [NUM_REGS];
    logic [7:0]            r_master;
    logic [PRESCALE_W-1:0] r_div;
    logic [VIB_W-1:0]      r_vib;
    logic [NOISE_W-1:0]    r_noise;
    logic [7:0]            r_tone  [NUM_TONES];
    logic [NUM_TONES-1:0]  r_level;

    logic [7:0]            n_master;
    logic [PRESCALE_W-1:0] n_div;
    logic [VIB_W-1:0]      n_vib;
    logic [NOISE_W-1:0]    n_noise;
    logic [7:0]            n_tone  [NUM_TONES];
    logic [NUM_TONES-1:0]  n_level;

    logic                  tick;
    logic                  wr;
    logic [2:0]            wr_idx;
    logic [SAMPLE_W-1:0]   mix;
    logic                  noise_fb;
    logic                  master_wrap;
    logic [3:0]            vib_pos;
    logic [7:0]            noise_rev;
    logic [7:0]            master_add;

    assign tick = i_accept && (t_kind'(i_kind) == KIND_TICK);
    assign wr   = i_accept && (t_kind'(i_kind) == KIND_WRITE);

    // Write decode: block transfers take the index from the high address byte
    assign wr_idx = i_port[BLOCK_XFER_POS] ? i_addr_high[2:0] : i_port[2:0];

    // Mixer, from state before this tick's update
    always_comb begin
        mix = '0;
        if (r_level[0]) mix = mix + SAMPLE_W'(r_regs[REG_VOLUME_AB][3:0]);
        if (r_level[1]) mix = mix + SAMPLE_W'(r_regs[REG_VOLUME_AB][7:4]);
        if (r_level[2]) mix = mix + SAMPLE_W'(r_regs[REG_NOISE_CTRL][3:0]);
        if (r_regs[REG_NOISE_CTRL][NOISE_EN_POS] && r_noise[NOISE_W-1])
            mix = mix + SAMPLE_W'(r_regs[REG_NOISE_VOL][7:4]);
    end

    assign o_result.valid  = tick;
    assign o_result.sample = mix;

    // Prescaler, XNOR LFSR and vibrato clock
    assign noise_fb = ~(r_noise[14] ^ r_noise[13]);
    always_comb begin
        n_div   = r_div + 1'b1;
        n_noise = r_noise;
        n_vib   = r_vib;
        if (r_div == PRESCALE_LAST) begin
            n_div   = '0;
            n_noise = {r_noise[NOISE_W-2:0], noise_fb};
            n_vib   = r_vib + 1'b1;
        end
    end

    // Master oscillator reload offset: vibrato depth or bit-reversed noise,
    // taken from the LFSR and vibrato clock after this tick's prescaler step
    assign vib_pos = VIB_TEST_POS + {2'b00, r_regs[REG_VIBRATO][7:6]};
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            noise_rev[7-b] = n_noise[7+b];
        end
    end

    always_comb begin
        master_add = '0;
        if (!r_regs[REG_NOISE_CTRL][MUX_NOISE_POS]) begin
            if (!n_vib[vib_pos]) master_add = {2'b00, r_regs[REG_VIBRATO][5:0]};
        end else begin
            master_add = noise_rev & r_regs[REG_NOISE_VOL];
        end
    end

    assign master_wrap = (r_master == 8'hff);

    // Master oscillator and tone dividers
    always_comb begin
        n_master = r_master + 1'b1;
        n_level  = r_level;
        for (int t = 0; t < NUM_TONES; t++) begin
            n_tone[t] = r_tone[t];
        end
        if (master_wrap) begin
            n_master = ~r_regs[REG_MASTER_FREQ] + master_add;
            for (int t = 0; t < NUM_TONES; t++) begin
                if (r_tone[t] == 8'hff) begin
                    n_level[t] = ~r_level[t];
                    n_tone[t]  = ~r_regs[REG_TONE_A_FREQ + 3'(t)];
                end else begin
                    n_tone[t]  = r_tone[t] + 1'b1;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) r_regs[k] <= '0;
            for (int t = 0; t < NUM_TONES; t++) r_tone[t] <= '0;
            r_master <= '0;
            r_div    <= '0;
            r_vib    <= '0;
            r_noise  <= '0;
            r_level  <= '0;
        end else begin
            if (wr) begin
                r_regs[wr_idx] <= i_write_data;
            end
            if (tick) begin
                r_master <= n_master;
                r_div    <= n_div;
                r_vib    <= n_vib;
                r_noise  <= n_noise;
                r_level  <= n_level;
                for (int t = 0; t < NUM_TONES; t++) r_tone[t] <= n_tone[t];
            end
        end
    end

    // Prescaler wraps to zero and clocks the LFSR
    a_div_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick && (r_div == PRESCALE_LAST) |=> (r_div == '0) && (r_noise[0] == $past(noise_fb)))
        else $error("prescaler wrap did not clock the LFSR");

    // Register writes leave the oscillators alone
    a_write_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr |=> $stable(r_master) && $stable(r_div) && $stable(r_level))
        else $error("oscillator state changed on a register write");

endmodule

FILE: src/tng_out.sv
// Result register between the mixer and the output channel.
// Depends on tng_pkg and tng_out_if.
module tng_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tng_pkg::t_result  i_result,
    output logic              o_ready,
    tng_out_if.source         o_out
);
    import tng_pkg::*;

    logic                r_valid;
    logic [SAMPLE_W-1:0] r_sample;

    // Can take a new result when empty or when the held one leaves this cycle
    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_result.valid) begin
            r_sample <= i_result.sample;
        end
    end

    assign o_out.valid  = r_valid;
    assign o_out.sample = r_sample;

    // Mixed level never exceeds four full-scale nibbles
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_sample <= SAMPLE_MAX))
        else $error("sample out of range");

    // A tick request always lands in the result register
    a_tick_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && i_result.valid |=> r_valid && (r_sample == $past(i_result.sample)))
        else $error("tick result lost");

endmodule

FILE: src/three_tone_noise_sound_generator_top.sv
// Top level of the three-tone noise sound generator.
// Depends on tng_pkg, tng_in_if, tng_out_if, tng_core and tng_out.
//
// One request per clock: a register write or a chip clock tick. A tick returns one sample
// (0..60) in the cycle after acceptance, taken from the mixer before that tick's oscillator
// update; a write returns nothing. All state advances in a single combinational pass
// into the state registers, so the only limit on rate is the single result register:
// i_in.ready is low only while a sample waits and o_out.ready is low.
module three_tone_noise_sound_generator_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tng_in_if.sink    i_in,
    tng_out_if.source o_out
);
    import tng_pkg::*;

    t_result res;
    logic    out_ready;

    assign i_in.ready = out_ready;

    tng_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (i_in.valid && out_ready),
        .i_kind       (i_in.kind),
        .i_port       (i_in.port),
        .i_addr_high  (i_in.addr_high),
        .i_write_data (i_in.write_data),
        .o_result     (res)
    );

    tng_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (res),
        .o_ready  (out_ready),
        .o_out    (o_out)
    );

endmodule
